>>> sv/damage_region_tracker_macros.svh
// ----------------------------------------------------------------------------
// damage_region_tracker_macros.svh
// assertion helpers shared by the damage region tracker rtl
// ----------------------------------------------------------------------------
`ifndef DAMAGE_REGION_TRACKER_MACROS_SVH
`define DAMAGE_REGION_TRACKER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// types and constants of the damage region tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

  // operation selector of an input word
  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_FULL    = 2'd1,
    MODE_CONSUME = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // field widths
  localparam int DIM_W   = 14;
  localparam int COORD_W = 16;
  localparam int BOX_W   = 17;
  localparam int CNT_W   = 7;

  // defaults
  localparam int RING_DEPTH_DEF    = 64;
  localparam int SCREEN_WIDTH_RST  = 1920;
  localparam int SCREEN_HEIGHT_RST = 1080;

  // partial redraw allowed below CLIP_NUM / CLIP_DEN of the screen area
  localparam int CLIP_NUM = 3;
  localparam int CLIP_DEN = 5;

endpackage

`default_nettype wire

>>> sv/damage_region_tracker.sv
// ----------------------------------------------------------------------------
// damage_region_tracker
// dirty rectangle bounding box tracker with redraw area decision
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in_      | input     | in_valid / in_ready   | mode, region x/y/w/h
//  out_     | output    | out_valid / out_ready | pending count, redraw, clip box
//  cfg_     | input     | cfg_we                | screen width / height
//
//  one word accepted per cycle while in_ready is high; its result goes through the clamp and result stages
//  box, flag and pending count update at the accept edge (clamp stage)
//  the area product and threshold compare run in the second stage
//  a stalled output keeps the clamp stage filled, then in_ready drops
//  synchronous reset; no clearing pass, usable the first cycle after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module damage_region_tracker
  import drt_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input words
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_mode,
  input  wire logic signed [COORD_W-1:0] in_region_x,
  input  wire logic signed [COORD_W-1:0] in_region_y,
  input  wire logic signed [COORD_W-1:0] in_region_w,
  input  wire logic signed [COORD_W-1:0] in_region_h,
  // result words
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CNT_W-1:0]               out_pending_count,
  output logic                           out_redraw,
  output logic                           out_partial,
  output logic [DIM_W-1:0]               out_clip_x,
  output logic [DIM_W-1:0]               out_clip_y,
  output logic [DIM_W-1:0]               out_clip_w,
  output logic [DIM_W-1:0]               out_clip_h,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [DIM_W-1:0]          cfg_wdata
);

  localparam int PEND_W  = $clog2(RING_DEPTH + 1);
  localparam int CEXT_W  = (PEND_W > CNT_W) ? PEND_W : CNT_W;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int CMP_W   = AREA_W + 3;
  localparam int EXT_W   = BOX_W + 1;

  // configuration and derived screen area
  logic [DIM_W-1:0]  sw_r, sh_r;
  logic [AREA_W-1:0] full_r;

  // tracker state
  logic [PEND_W-1:0]      pending_r, pending_nxt;
  logic                   flag_r, flag_nxt;
  logic                   box_valid_r, box_valid_nxt;
  logic signed [BOX_W-1:0] left_r, top_r, right_r, bottom_r;
  logic signed [BOX_W-1:0] left_nxt, top_nxt, right_nxt, bottom_nxt;

  // clamp stage
  logic             a_valid_r;
  logic [CNT_W-1:0] a_cnt_r, a_cnt_nxt;
  logic             a_redraw_r, a_redraw_nxt;
  logic             a_cand_r, a_cand_nxt;
  logic [DIM_W-1:0] a_x0_r, a_y0_r, a_ew_r, a_eh_r;
  logic [DIM_W-1:0] a_x0_nxt, a_y0_nxt, a_ew_nxt, a_eh_nxt;

  // result stage
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_redraw_r, out_clip_r;
  logic [DIM_W-1:0] out_x_r, out_y_r, out_w_r, out_h_r;
  logic [DIM_W-1:0] out_x_nxt, out_y_nxt, out_w_nxt, out_h_nxt;
  logic             out_clip_nxt;

  // handshake
  logic  out_load, accept;
  mode_t mode;

  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || out_load;
  assign accept   = in_valid && in_ready;
  assign mode     = mode_t'(in_mode);

  // grow operands
  logic signed [BOX_W-1:0] gx, gy, gw, gh, gr, gb;
  logic                    is_push, grow_en;

  // clamp operands
  logic signed [BOX_W-1:0] sw_s, sh_s, x0, y0, x1, y1;
  logic signed [EXT_W-1:0] ew, eh;
  logic                    ext_pos;
  logic [CEXT_W-1:0]       cnt_ext;
  logic [PEND_W-1:0]       count;

  // update of tracker state for the word at the input
  always_comb begin
    is_push = 1'b0;
    gx      = '0;
    gy      = '0;
    gw      = '0;
    gh      = '0;
    unique case (mode)
      MODE_PUSH: begin
        is_push = 1'b1;
        gx      = BOX_W'(in_region_x);
        gy      = BOX_W'(in_region_y);
        gw      = BOX_W'(in_region_w);
        gh      = BOX_W'(in_region_h);
      end
      MODE_FULL: begin
        is_push = 1'b1;
        gw      = $signed({{(BOX_W-DIM_W){1'b0}}, sw_r});
        gh      = $signed({{(BOX_W-DIM_W){1'b0}}, sh_r});
      end
      default: begin
        is_push = 1'b0;
      end
    endcase
    gr      = gx + gw;
    gb      = gy + gh;
    grow_en = is_push && (gw > 0) && (gh > 0);

    // clamp box to the screen
    sw_s    = $signed({{(BOX_W-DIM_W){1'b0}}, sw_r});
    sh_s    = $signed({{(BOX_W-DIM_W){1'b0}}, sh_r});
    x0      = left_r[BOX_W-1] ? '0 : left_r;
    y0      = top_r[BOX_W-1] ? '0 : top_r;
    x1      = (right_r > sw_s) ? sw_s : right_r;
    y1      = (bottom_r > sh_s) ? sh_s : bottom_r;
    ew      = EXT_W'(x1) - EXT_W'(x0);
    eh      = EXT_W'(y1) - EXT_W'(y0);
    ext_pos = (ew > 0) && (eh > 0);

    // defaults: hold
    pending_nxt   = pending_r;
    flag_nxt      = flag_r;
    box_valid_nxt = box_valid_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    right_nxt     = right_r;
    bottom_nxt    = bottom_r;
    a_redraw_nxt  = 1'b0;
    a_cand_nxt    = 1'b0;

    // bounding box growth
    if (grow_en) begin
      box_valid_nxt = 1'b1;
      if (!box_valid_r) begin
        left_nxt   = gx;
        top_nxt    = gy;
        right_nxt  = gr;
        bottom_nxt = gb;
      end else begin
        if (gx < left_r)   left_nxt   = gx;
        if (gy < top_r)    top_nxt    = gy;
        if (gr > right_r)  right_nxt  = gr;
        if (gb > bottom_r) bottom_nxt = gb;
      end
    end

    // pending count, flag and consume
    if (is_push && (pending_r < PEND_W'(RING_DEPTH))) begin
      pending_nxt = pending_r + PEND_W'(1);
    end
    if (mode == MODE_FULL) begin
      flag_nxt = 1'b1;
    end
    if (mode == MODE_CONSUME) begin
      pending_nxt = '0;
      if (pending_r != '0) begin
        a_redraw_nxt  = 1'b1;
        a_cand_nxt    = !flag_r && box_valid_r && ext_pos;
        box_valid_nxt = 1'b0;
        flag_nxt      = 1'b0;
      end
    end

    count     = is_push ? pending_nxt : pending_r;
    cnt_ext   = CEXT_W'(count);
    a_cnt_nxt = cnt_ext[CNT_W-1:0];
    a_x0_nxt  = x0[DIM_W-1:0];
    a_y0_nxt  = y0[DIM_W-1:0];
    a_ew_nxt  = ew[DIM_W-1:0];
    a_eh_nxt  = eh[DIM_W-1:0];
  end

  // area compare: area < floor(full * num / den)  <=>  den * (area + 1) <= num * full
  logic [AREA_W-1:0] area;
  logic [CMP_W-1:0]  lhs, rhs;

  always_comb begin
    area         = a_ew_r * a_eh_r;
    lhs          = CMP_W'(area) * CMP_W'(CLIP_DEN) + CMP_W'(CLIP_DEN);
    rhs          = CMP_W'(full_r) * CMP_W'(CLIP_NUM);
    out_clip_nxt = a_redraw_r && a_cand_r && (lhs <= rhs);
    out_x_nxt    = '0;
    out_y_nxt    = '0;
    out_w_nxt    = '0;
    out_h_nxt    = '0;
    if (out_clip_nxt) begin
      out_x_nxt = a_x0_r;
      out_y_nxt = a_y0_r;
      out_w_nxt = a_ew_r;
      out_h_nxt = a_eh_r;
    end else if (a_redraw_r) begin
      out_w_nxt = sw_r;
      out_h_nxt = sh_r;
    end
  end

  // configuration registers and screen area
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= DIM_W'(SCREEN_WIDTH_RST);
      sh_r   <= DIM_W'(SCREEN_HEIGHT_RST);
      full_r <= AREA_W'(SCREEN_WIDTH_RST * SCREEN_HEIGHT_RST);
    end else begin
      full_r <= sw_r * sh_r;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  sw_r <= cfg_wdata;
          REG_SCREEN_HEIGHT: sh_r <= cfg_wdata;
          default:           sw_r <= sw_r;
        endcase
      end
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= PEND_W'(1);
      flag_r      <= 1'b1;
      box_valid_r <= 1'b0;
    end else if (accept) begin
      pending_r   <= pending_nxt;
      flag_r      <= flag_nxt;
      box_valid_r <= box_valid_nxt;
    end
  end

  // box edges, qualified by box_valid_r
  always_ff @(posedge clk) begin
    if (accept) begin
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  // clamp stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cnt_r    <= a_cnt_nxt;
      a_redraw_r <= a_redraw_nxt;
      a_cand_r   <= a_cand_nxt;
      a_x0_r     <= a_x0_nxt;
      a_y0_r     <= a_y0_nxt;
      a_ew_r     <= a_ew_nxt;
      a_eh_r     <= a_eh_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && a_valid_r) begin
      out_cnt_r    <= a_cnt_r;
      out_redraw_r <= a_redraw_r;
      out_clip_r   <= out_clip_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_w_r      <= out_w_nxt;
      out_h_r      <= out_h_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pending_count = out_cnt_r;
  assign out_redraw        = out_redraw_r;
  assign out_partial       = out_clip_r;
  assign out_clip_x        = out_x_r;
  assign out_clip_y        = out_y_r;
  assign out_clip_w        = out_w_r;
  assign out_clip_h        = out_h_r;

  // checks
`include "damage_region_tracker_macros.svh"

  `DRT_ASSERT_ALWAYS(a_pend_bound, pending_r <= PEND_W'(RING_DEPTH), "pending above ring depth")
  `DRT_ASSERT_IMPL(a_clip_needs_redraw, out_valid_r && out_clip_r, out_redraw_r, "clip without redraw")
  `DRT_ASSERT_IMPL(a_no_overrun, a_valid_r && out_valid_r && !out_ready, !in_ready, "stage overrun")
  `DRT_ASSERT_NEXT(a_consume_clears, accept && (mode == MODE_CONSUME) && (pending_r != '0), (pending_r == '0) && !box_valid_r && !flag_r, "consume left state")

endmodule

`default_nettype wire
